// File: rtl/core/wilder_rsi_stream_top_assert.svh
// assertion macros shared by wrsi_div and wrsi_core
`ifndef WILDER_RSI_STREAM_TOP_ASSERT_SVH
`define WILDER_RSI_STREAM_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WRSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wrsi assertion failed");

// next-cycle implication, checked outside reset
`define WRSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wrsi assertion failed");

`endif

// File: rtl/core/wrsi_pkg.sv
`default_nettype none
package wrsi_pkg;

  localparam int PRICE_WIDTH = 32;
  localparam int AVG_BITS  = 48;
  localparam int DIV_W     = AVG_BITS + 1;
  localparam int PERIOD_W  = 8;
  localparam int RSI_W     = 23;
  localparam int RSI_FRAC  = 16;
  localparam int WILDER_W  = 64;
  localparam int ITER_W    = 7;
  localparam int RSI_MUL   = 100;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
  localparam logic [RSI_W-1:0]    RSI_FULL     = 23'd6553600;
  localparam logic [RSI_W-1:0]    RSI_HALF     = 23'd3276800;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic             emit;
    logic [RSI_W-1:0] value;
  } rsi_out_t;

endpackage
`default_nettype wire

// File: rtl/core/wrsi_if.sv
`default_nettype none
interface wrsi_price_if;
  logic                             valid;
  logic                             ready;
  logic [wrsi_pkg::PRICE_WIDTH-1:0] price;
  logic                             restart;

  modport source (output valid, output price, output restart, input ready);
  modport sink (input valid, input price, input restart, output ready);
endinterface

interface wrsi_rsi_if;
  logic                           valid;
  logic                           ready;
  logic [wrsi_pkg::RSI_W-1:0]     rsi_value;

  modport source (output valid, output rsi_value, input ready);
  modport sink (input valid, input rsi_value, output ready);
endinterface

interface wrsi_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wrsi_pkg::PERIOD_W-1:0]  period;

  modport source (output valid, output period, input ready);
  modport sink (input valid, input period, output ready);
endinterface
`default_nettype wire

// File: rtl/core/wilder_rsi_stream_top.sv
// wilder rsi over a stream of unsigned q24.8 prices
// channels: samples (price, restart) in, rsi (rsi_value, q7.16) out, cfg
// (period) writes the smoothing length; cfg is always ready. the user must
// see that cfg is written only while the block is idle; the block itself
// does not enforce this. period zero acts as one. one item at a time:
// samples.ready is high only while the sequencer idles. a first price, a
// restart price or a warm-up price gives no transaction. the price that
// completes the warm-up runs two scaling divisions of D quotient bits each,
// D = max(64, 48+AVG_FRAC_BITS). a later price runs two smoothing divisions
// and, unless both averages are zero, one 23-step ratio division on the
// single shared restoring divider, one quotient bit per cycle.
// the result goes to an output register; the next price is taken while it
// waits. if the receiver stalls with that register full, the next result
// holds in the sequencer until the register frees.
// reset (rst, synchronous) sets period to 14 and clears the series; no
// memory clearing pass is needed.
`default_nettype none
module wilder_rsi_stream_top #(
  parameter int AVG_FRAC_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  wrsi_price_if.sink           samples,
  wrsi_rsi_if.source           rsi,
  wrsi_cfg_if.sink             cfg
);

  logic [wrsi_pkg::PERIOD_W-1:0]  period;
  logic [wrsi_pkg::PERIOD_W-1:0]  period_eff;
  logic                           out_valid;
  logic [wrsi_pkg::RSI_W-1:0]     out_value;
  logic                           out_free;
  logic                           core_ready;
  wrsi_pkg::rsi_out_t             core_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= wrsi_pkg::PERIOD_RESET;
    end else if (cfg.valid) begin
      period <= cfg.period;
    end
  end

  assign cfg.ready  = 1'b1;
  assign period_eff = (period == '0) ? wrsi_pkg::PERIOD_W'(1) : period;

  // output register
  assign out_free = !out_valid || rsi.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_out.emit) begin
      out_valid <= 1'b1;
    end else if (rsi.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_out.emit) begin
      out_value <= core_out.value;
    end
  end

  assign rsi.valid     = out_valid;
  assign rsi.rsi_value = out_value;
  assign samples.ready = core_ready;

  wrsi_core #(
    .PRICE_WIDTH   (wrsi_pkg::PRICE_WIDTH),
    .AVG_FRAC_BITS (AVG_FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .period     (period_eff),
    .in_valid   (samples.valid),
    .in_price   (samples.price),
    .in_restart (samples.restart),
    .in_ready   (core_ready),
    .out_free   (out_free),
    .out        (core_out)
  );

endmodule
`default_nettype wire

// File: rtl/core/wrsi_div.sv
`default_nettype none
module wrsi_div #(
  parameter int DW = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire wrsi_pkg::div_ctrl_t     ctrl,
  input  wire [DW-1:0]                 dividend,
  input  wire [wrsi_pkg::DIV_W-1:0]    divisor,
  input  wire [wrsi_pkg::DIV_W-1:0]    rem_init,
  output wrsi_pkg::div_stat_t          stat,
  output logic [DW-1:0]                quotient
);

  logic [DW-1:0]                 dreg;
  logic [wrsi_pkg::DIV_W-1:0]    rem;
  logic [wrsi_pkg::DIV_W-1:0]    dsr;
  logic [wrsi_pkg::ITER_W-1:0]   cnt;
  logic                          busy;
  logic                          done;
  logic [wrsi_pkg::DIV_W:0]      shifted;
  logic                          fits;

  assign shifted = {rem, dreg[DW-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ctrl.iters;
        dreg <= dividend;
        rem  <= rem_init;
        dsr  <= divisor;
      end else if (busy) begin
        if (fits) begin
          rem <= wrsi_pkg::DIV_W'(shifted - {1'b0, dsr});
        end else begin
          rem <= shifted[wrsi_pkg::DIV_W-1:0];
        end
        dreg <= {dreg[DW-2:0], fits};
        cnt  <= cnt - wrsi_pkg::ITER_W'(1);
        if (cnt == wrsi_pkg::ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dreg;

`include "wilder_rsi_stream_top_assert.svh"

  `WRSI_ASSERT_IMP(a_start_idle, ctrl.start, !busy)
  `WRSI_ASSERT_IMP(a_rem_below, busy, rem < dsr)
  `WRSI_ASSERT_IMP(a_done_free, done, !busy)

endmodule
`default_nettype wire

// File: rtl/core/wrsi_core.sv
`default_nettype none
module wrsi_core #(
  parameter int PRICE_WIDTH   = 32,
  parameter int AVG_FRAC_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire [wrsi_pkg::PERIOD_W-1:0]    period,
  input  wire                             in_valid,
  input  wire [PRICE_WIDTH-1:0]           in_price,
  input  wire                             in_restart,
  output logic                            in_ready,
  input  wire                             out_free,
  output wrsi_pkg::rsi_out_t              out
);

  localparam int AB = wrsi_pkg::AVG_BITS;
  localparam int SW = AB + AVG_FRAC_BITS;
  localparam int DW = (SW > wrsi_pkg::WILDER_W) ? SW : wrsi_pkg::WILDER_W;
  localparam int NL = wrsi_pkg::RSI_W - wrsi_pkg::RSI_FRAC;
  localparam int NW = AB + 7;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCG   = 4'd1;
  localparam logic [3:0] S_SCG_W = 4'd2;
  localparam logic [3:0] S_SCL   = 4'd3;
  localparam logic [3:0] S_SCL_W = 4'd4;
  localparam logic [3:0] S_WG    = 4'd5;
  localparam logic [3:0] S_WG_W  = 4'd6;
  localparam logic [3:0] S_WL    = 4'd7;
  localparam logic [3:0] S_WL_W  = 4'd8;
  localparam logic [3:0] S_RSI   = 4'd9;
  localparam logic [3:0] S_RSI_W = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]                     state;
  logic [PRICE_WIDTH-1:0]         last_price;
  logic                           have_last;
  logic [wrsi_pkg::PERIOD_W-1:0]  change_count;
  logic [AB-1:0]                  gain_average;
  logic [AB-1:0]                  loss_average;
  logic [PRICE_WIDTH-1:0]         gain_x;
  logic [PRICE_WIDTH-1:0]         loss_x;
  logic [wrsi_pkg::RSI_W-1:0]     rsi_value;

  logic [PRICE_WIDTH-1:0]         gain;
  logic [PRICE_WIDTH-1:0]         loss;
  logic [wrsi_pkg::PERIOD_W-1:0]  count_next;
  logic [wrsi_pkg::PERIOD_W-1:0]  pm1;
  logic [AB-1:0]                  avg_sel;
  logic [PRICE_WIDTH-1:0]         x_sel;
  logic [AB+wrsi_pkg::PERIOD_W-1:0] prod;
  logic [wrsi_pkg::WILDER_W-1:0]  num;
  logic [wrsi_pkg::DIV_W-1:0]     sum_gl;
  logic [NW-1:0]                  n_mul;
  logic [wrsi_pkg::RSI_W-1:0]     q_rsi;
  logic                           div_wait;

  wrsi_pkg::div_ctrl_t            div_ctrl;
  wrsi_pkg::div_stat_t            div_stat;
  logic [DW-1:0]                  div_dividend;
  logic [wrsi_pkg::DIV_W-1:0]     div_divisor;
  logic [wrsi_pkg::DIV_W-1:0]     div_rem_init;
  logic [DW-1:0]                  div_quot;

  assign gain       = (in_price > last_price) ? in_price - last_price : '0;
  assign loss       = (in_price > last_price) ? '0 : last_price - in_price;
  assign count_next = change_count + wrsi_pkg::PERIOD_W'(1);
  assign pm1        = period - wrsi_pkg::PERIOD_W'(1);

  // wilder numerator, wraps at 64 bits
  assign avg_sel = (state == S_WG) ? gain_average : loss_average;
  assign x_sel   = (state == S_WG) ? gain_x : loss_x;
  assign prod    = (AB+wrsi_pkg::PERIOD_W)'(avg_sel) * (AB+wrsi_pkg::PERIOD_W)'(pm1);
  assign num     = wrsi_pkg::WILDER_W'(prod)
                 + wrsi_pkg::WILDER_W'({x_sel, {AVG_FRAC_BITS{1'b0}}});

  assign sum_gl = {1'b0, gain_average} + {1'b0, loss_average};
  assign n_mul  = NW'(gain_average) * NW'(wrsi_pkg::RSI_MUL);
  assign q_rsi  = div_quot[wrsi_pkg::RSI_W-1:0];

  assign div_wait = (state == S_SCG_W) || (state == S_SCL_W) || (state == S_WG_W)
                 || (state == S_WL_W) || (state == S_RSI_W);

  always_comb begin
    div_ctrl.start = 1'b0;
    div_ctrl.iters = wrsi_pkg::ITER_W'(DW);
    div_dividend   = '0;
    div_divisor    = wrsi_pkg::DIV_W'(period);
    div_rem_init   = '0;
    unique case (state) inside
      S_SCG: begin
        div_ctrl.start = 1'b1;
        div_dividend   = DW'({gain_average, {AVG_FRAC_BITS{1'b0}}});
      end
      S_SCL: begin
        div_ctrl.start = 1'b1;
        div_dividend   = DW'({loss_average, {AVG_FRAC_BITS{1'b0}}});
      end
      S_WG, S_WL: begin
        div_ctrl.start = 1'b1;
        div_dividend   = DW'(num);
      end
      S_RSI: begin
        // quotient fits in the rsi width, so start from the top partial remainder
        div_ctrl.start = sum_gl != '0;
        div_ctrl.iters = wrsi_pkg::ITER_W'(wrsi_pkg::RSI_W);
        div_dividend   = {n_mul[NL-1:0], {(DW-NL){1'b0}}};
        div_divisor    = sum_gl;
        div_rem_init   = wrsi_pkg::DIV_W'(n_mul[NW-1:NL]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      have_last    <= 1'b0;
      change_count <= '0;
      gain_average <= '0;
      loss_average <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_price <= in_price;
            if (in_restart || !have_last) begin
              have_last    <= 1'b1;
              change_count <= '0;
              gain_average <= '0;
              loss_average <= '0;
            end else if (change_count < period) begin
              gain_average <= gain_average + AB'(gain);
              loss_average <= loss_average + AB'(loss);
              change_count <= count_next;
              if (count_next == period) begin
                state <= S_SCG;
              end
            end else begin
              gain_x <= gain;
              loss_x <= loss;
              state  <= S_WG;
            end
          end
        end
        S_SCG: state <= S_SCG_W;
        S_SCG_W: begin
          if (div_stat.done) begin
            gain_average <= div_quot[AB-1:0];
            state        <= S_SCL;
          end
        end
        S_SCL: state <= S_SCL_W;
        S_SCL_W: begin
          if (div_stat.done) begin
            loss_average <= div_quot[AB-1:0];
            state        <= S_IDLE;
          end
        end
        S_WG: state <= S_WG_W;
        S_WG_W: begin
          if (div_stat.done) begin
            gain_average <= div_quot[AB-1:0];
            state        <= S_WL;
          end
        end
        S_WL: state <= S_WL_W;
        S_WL_W: begin
          if (div_stat.done) begin
            loss_average <= div_quot[AB-1:0];
            state        <= S_RSI;
          end
        end
        S_RSI: begin
          if (sum_gl == '0) begin
            rsi_value <= wrsi_pkg::RSI_HALF;
            state     <= S_OUT;
          end else begin
            state <= S_RSI_W;
          end
        end
        S_RSI_W: begin
          if (div_stat.done) begin
            rsi_value <= (q_rsi > wrsi_pkg::RSI_FULL) ? wrsi_pkg::RSI_FULL : q_rsi;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = state == S_IDLE;
  assign out.emit  = (state == S_OUT) && out_free;
  assign out.value = rsi_value;

  wrsi_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rem_init (div_rem_init),
    .stat     (div_stat),
    .quotient (div_quot)
  );

`include "wilder_rsi_stream_top_assert.svh"

  `WRSI_ASSERT_IMP(a_done_waits, div_stat.done, div_wait)
  `WRSI_ASSERT_IMP(a_idle_div_free, state == S_IDLE, !div_stat.busy)
  `WRSI_ASSERT_IMP(a_count_series, !have_last, change_count == '0)

endmodule
`default_nettype wire

// File: dv/tb_wilder_rsi_stream_top.sv
`default_nettype none
module tb_wilder_rsi_stream_top;

  localparam int AVG_FRAC       = 16;
  localparam int SETTLE_CYCLES  = 400;
  localparam int QUIET_LIMIT    = 20000;
  localparam int HOLD_OFF       = 3000;
  localparam int PRINT_LIMIT    = 40;

  logic clk;
  logic rst;

  wrsi_price_if samples_if ();
  wrsi_rsi_if   rsi_if ();
  wrsi_cfg_if   cfg_if ();

  wilder_rsi_stream_top uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .rsi     (rsi_if),
    .cfg     (cfg_if)
  );

  // series state mirrored from the block
  logic [wrsi_pkg::PERIOD_W-1:0] period_reg;
  logic [31:0]                   series_last_price;
  logic                          series_started;
  logic [7:0]                    changes_seen;
  logic [wrsi_pkg::AVG_BITS-1:0] gain_avg;
  logic [wrsi_pkg::AVG_BITS-1:0] loss_avg;

  logic [wrsi_pkg::RSI_W-1:0] rsi_expected [$];
  logic [wrsi_pkg::RSI_W-1:0] rsi_want;
  logic [31:0]                walk_price;

  int fail_count      = 0;
  int prices_sent     = 0;
  int results_checked = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int rsi_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [wrsi_pkg::AVG_BITS-1:0] scaled_mean(input logic [63:0] sum,
                                                                input logic [63:0] p);
    logic [63:0] q;
    logic [63:0] r;
    q = sum / p;
    r = sum % p;
    return (q << AVG_FRAC) + ((r << AVG_FRAC) / p);
  endfunction

  function automatic logic [wrsi_pkg::AVG_BITS-1:0] wilder_smooth(input logic [63:0] avg,
                                                                  input logic [63:0] x,
                                                                  input logic [63:0] p);
    logic [63:0] num;
    num = avg * (p - 64'd1) + (x << AVG_FRAC);
    return num / p;
  endfunction

  // returns 1 when the price yields an rsi transaction
  function automatic bit step_series(input logic [31:0] price, input logic restart,
                                     output logic [wrsi_pkg::RSI_W-1:0] rsi_out);
    logic [63:0] p;
    logic [63:0] gain;
    logic [63:0] loss;
    logic [63:0] total;
    logic [63:0] quo;
    logic [63:0] rem;
    p = (period_reg == '0) ? 64'd1 : 64'(period_reg);
    gain = '0;
    loss = '0;
    rsi_out = '0;
    if (restart) begin
      series_started = 1'b0;
      changes_seen = '0;
      gain_avg = '0;
      loss_avg = '0;
    end
    if (!series_started) begin
      series_last_price = price;
      series_started = 1'b1;
      return 1'b0;
    end
    if (price > series_last_price) gain = 64'(price - series_last_price);
    else loss = 64'(series_last_price - price);
    series_last_price = price;
    if (64'(changes_seen) < p) begin
      gain_avg = gain_avg + gain[wrsi_pkg::AVG_BITS-1:0];
      loss_avg = loss_avg + loss[wrsi_pkg::AVG_BITS-1:0];
      changes_seen = changes_seen + 8'd1;
      if (64'(changes_seen) == p) begin
        gain_avg = scaled_mean(64'(gain_avg), p);
        loss_avg = scaled_mean(64'(loss_avg), p);
      end
      return 1'b0;
    end
    gain_avg = wilder_smooth(64'(gain_avg), gain, p);
    loss_avg = wilder_smooth(64'(loss_avg), loss, p);
    total = 64'(gain_avg) + 64'(loss_avg);
    if (total == '0) begin
      rsi_out = wrsi_pkg::RSI_HALF;
    end else begin
      quo = (64'(gain_avg) * 64'(wrsi_pkg::RSI_MUL)) / total;
      rem = (64'(gain_avg) * 64'(wrsi_pkg::RSI_MUL)) % total;
      for (int i = 0; i < wrsi_pkg::RSI_FRAC; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= total) begin
          rem = rem - total;
          quo = quo | 64'd1;
        end
      end
      rsi_out = (quo > 64'(wrsi_pkg::RSI_FULL)) ? wrsi_pkg::RSI_FULL
                                                : quo[wrsi_pkg::RSI_W-1:0];
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [wrsi_pkg::RSI_W-1:0] got,
                                 input logic [wrsi_pkg::RSI_W-1:0] want);
    if (fail_count < PRINT_LIMIT)
      $display("mismatch: %s, rsi_value %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  task automatic send_price(input logic [31:0] price, input logic restart);
    logic [wrsi_pkg::RSI_W-1:0] predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(negedge clk);
    end
    samples_if.valid   <= 1'b1;
    samples_if.price   <= price;
    samples_if.restart <= restart;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    prices_sent++;
    if (step_series(price, restart, predicted))
      rsi_expected.insert(rsi_expected.size(), predicted);
  endtask

  task automatic drain_block();
    @(negedge clk);
    samples_if.valid <= 1'b0;
    while (rsi_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [wrsi_pkg::PERIOD_W-1:0] value);
    drain_block();
    @(negedge clk);
    cfg_if.valid  <= 1'b1;
    cfg_if.period <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    period_reg = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [31:0] next_price();
    int unsigned pick;
    logic [31:0] step;
    pick = $urandom_range(99);
    step = $urandom() >> $urandom_range(31, 8);
    if (pick < 42) walk_price = walk_price + step;
    else if (pick < 84) walk_price = walk_price - step;
    else if (pick < 89) walk_price = $urandom();
    else if (pick < 91) walk_price = '0;
    else if (pick < 93) walk_price = '1;
    return walk_price;
  endfunction

  task automatic test_directed_extremes();
    write_period(8'd2);
    send_price(32'd0, 1'b1);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'd0, 1'b0);
    send_price(32'd0, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    // flat series: both averages zero
    send_price(32'd5, 1'b1);
    send_price(32'd5, 1'b0);
    send_price(32'd5, 1'b0);
    send_price(32'd5, 1'b0);
    // rising series with no losses, then one falling price
    send_price(32'd10, 1'b1);
    send_price(32'd20, 1'b0);
    send_price(32'd30, 1'b0);
    send_price(32'd40, 1'b0);
    send_price(32'd35, 1'b0);
    // restart on the very next price
    send_price(32'h8000_0000, 1'b1);
    send_price(32'h7FFF_FFFF, 1'b1);
    send_price(32'h0000_0001, 1'b0);
    send_price(32'hAAAA_5555, 1'b0);
    send_price(32'h5555_AAAA, 1'b0);
  endtask

  task automatic test_period_changes();
    write_period(8'd4);
    send_price(32'h0001_0000, 1'b1);
    repeat (5) send_price(next_price(), 1'b0);
    // longer period sends the series back to warm-up
    write_period(8'd8);
    repeat (3) send_price(next_price(), 1'b0);
    write_period(8'd1);
    repeat (3) send_price(next_price(), 1'b0);
    write_period(8'd0);
    repeat (3) send_price(next_price(), 1'b0);
    write_period(8'd255);
    repeat (2) send_price(next_price(), 1'b0);
    write_period(wrsi_pkg::PERIOD_RESET);
    send_price(next_price(), 1'b0);
  endtask

  task automatic test_output_backpressure();
    int saved_idle;
    saved_idle = send_idle_pct;
    write_period(8'd2);
    send_idle_pct = 0;
    rsi_hold_cycles = HOLD_OFF;
    send_price(next_price(), 1'b1);
    repeat (40) send_price(next_price(), 1'b0);
    send_idle_pct = saved_idle;
  endtask

  task automatic test_random_series(input logic [wrsi_pkg::PERIOD_W-1:0] value,
                                    input int count);
    int span;
    write_period(value);
    span = 2 * int'(value) + 20;
    for (int i = 0; i < count; i++)
      send_price(next_price(), $urandom_range(span) == 0);
  endtask

  initial begin
    rsi_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsi_hold_cycles > 0) begin
        rsi_if.ready <= 1'b0;
        rsi_hold_cycles--;
      end else begin
        rsi_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsi_if.valid && rsi_if.ready) begin
      if (rsi_expected.size() == 0) begin
        report_mismatch("rsi transaction with nothing expected", rsi_if.rsi_value, '0);
      end else begin
        rsi_want = rsi_expected.pop_front();
        if (rsi_if.rsi_value !== rsi_want)
          report_mismatch("rsi_value differs", rsi_if.rsi_value, rsi_want);
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (samples_if.valid && samples_if.ready) || (rsi_if.valid && rsi_if.ready)
          || (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [wrsi_pkg::PERIOD_W-1:0] periods [9];
    rst = 1'b1;
    samples_if.valid   = 1'b0;
    samples_if.price   = '0;
    samples_if.restart = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.period = '0;
    period_reg = wrsi_pkg::PERIOD_RESET;
    series_last_price = '0;
    series_started = 1'b0;
    changes_seen = '0;
    gain_avg = '0;
    loss_avg = '0;
    walk_price = $urandom();
    periods = '{8'd1, 8'd14, 8'd255, 8'd2, 8'd0, 8'($urandom_range(40, 3)),
                8'd7, 8'($urandom_range(100, 1)), 8'd3};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    recv_stall_pct = 61;
    test_directed_extremes();
    test_period_changes();
    test_output_backpressure();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 35 : (phase == 1) ? 61 : 0;
      recv_stall_pct = (phase == 0) ? 61 : (phase == 1) ? 35 : 0;
      for (int k = 0; k < 3; k++)
        test_random_series(periods[phase*3+k], (periods[phase*3+k] > 100) ? 400 : 150);
    end
    drain_block();

    $display("%0d prices sent, %0d rsi transactions checked, %0d mismatches",
             prices_sent, results_checked, fail_count);
    $display("periods 0, 1, 2, 14, 255 and random, mid-series period changes, "
             , "idle and stall on both sides, long output hold-off");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
